// ===== hw/rtl/brlpg_pkg.sv =====
// Package for the Bresenham line pixel generator.
// Command codes, register indexes, widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package brlpg_pkg;

   // default parameter values
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int STEP_LIMIT_DEFAULT = 10000;

   // command codes carried in req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // configuration registers
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  IMAGE_SIZE_RESET = 12'd256;

   // pixel colour word
   localparam int COLOR_W = 32;

endpackage

// ===== hw/rtl/brlpg_skid.sv =====
// Two-entry output buffer: result register plus skid register.
// Keeps the input side ready while one result waits downstream.
// No package dependencies.
`timescale 1ns / 1ps

module brlpg_skid #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             push;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         // output slot frees up: drain skid first, else take new item
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_data_in  = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== hw/rtl/bresenham_line_pixel_generator.sv =====
// Bresenham line pixel generator, top level.
// Depends on brlpg_pkg and brlpg_skid.
`timescale 1ns / 1ps

// Usage:
//  req_* : command items. tuser = command (load or step). tdata = start_x,
//          start_y, finish_x, finish_y, line_color from the lowest bit up.
//          A load sets up the line and gives no result; a load while busy
//          drops the current line. A step while idle gives nothing.
//  rsp_* : one pixel item per step while busy. tdata = pixel_x, pixel_y,
//          pixel_color; tuser = inside_res; tlast = end point of the line.
//  csr_* : image_width / image_height for the inside test, write only,
//          taken at any edge with csr_wen high.
// Timing: the line state registers update in the cycle an item is taken,
//  and its pixel goes into the result register, or the skid register if
//  that is held. One item per cycle while req_tready is high; the rate is
//  set by the error-term update loop (compares, two adds) on the line state.
// Stall: a two-entry result buffer keeps req_tready high while one pixel
//  waits; req_tready drops only when both entries are full.
// Reset: synchronous, active high; idle, image size 256 x 256, no pixels.
module bresenham_line_pixel_generator #(
   parameter int COORD_BITS = brlpg_pkg::COORD_BITS_DEFAULT,
   parameter int STEP_LIMIT = brlpg_pkg::STEP_LIMIT_DEFAULT,
   localparam int REQ_FIELDS_W = 4 * COORD_BITS + brlpg_pkg::COLOR_W,
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8,
   localparam int RSP_FIELDS_W = 2 * COORD_BITS + brlpg_pkg::COLOR_W,
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_x, start_y, finish_x, finish_y, line_color (low to high)
   input  logic [REQ_TDATA_W-1:0]             req_tdata,
   // command
   input  logic                               req_tuser,
   // pixel channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_x, pixel_y, pixel_color (low to high)
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,
   // inside_res
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // register writes
   input  logic                               csr_wen,
   input  logic [brlpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [brlpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int C      = COORD_BITS;
   localparam int ERR_W  = C + 2;
   localparam int E2_W   = C + 3;
   localparam int SL_W   = $clog2(STEP_LIMIT + 1);
   localparam int CMP_W  = ((C > brlpg_pkg::CSR_DATA_W) ? C : brlpg_pkg::CSR_DATA_W) + 1;
   localparam int SKID_W = RSP_FIELDS_W + 2;

   // configuration
   logic [brlpg_pkg::CSR_DATA_W-1:0] image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= brlpg_pkg::IMAGE_SIZE_RESET;
         image_height_ff <= brlpg_pkg::IMAGE_SIZE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            brlpg_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            brlpg_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // line state
   logic signed [C-1:0]     cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic signed [C-1:0]     target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [C-1:0]            delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic                    step_x_neg_ff, step_x_neg_in, step_y_neg_ff, step_y_neg_in;
   logic signed [ERR_W-1:0] error_ff, error_in;
   logic [SL_W-1:0]         steps_left_ff, steps_left_in;
   logic [brlpg_pkg::COLOR_W-1:0] color_ff, color_in;
   logic                    busy_ff, busy_in;

   // item fields
   logic signed [C-1:0] start_x, start_y, finish_x, finish_y;
   logic [brlpg_pkg::COLOR_W-1:0] line_color;

   assign start_x    = req_tdata[C-1:0];
   assign start_y    = req_tdata[2*C-1:C];
   assign finish_x   = req_tdata[3*C-1:2*C];
   assign finish_y   = req_tdata[4*C-1:3*C];
   assign line_color = req_tdata[REQ_FIELDS_W-1:4*C];

   logic accept, produce, at_end;
   logic signed [C:0]      diff_x, diff_y, abs_x, abs_y;
   logic signed [E2_W-1:0] e2, dx_ext, dy_ext, err_wide;
   logic                   move_x, move_y;

   // result
   logic signed [C-1:0] res_x, res_y;
   logic                res_last, res_inside;
   logic [SKID_W-1:0]   res_data, out_data;
   logic                skid_ready;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = skid_ready;
   assign at_end     = (cursor_x_ff == target_x_ff && cursor_y_ff == target_y_ff)
                       || (steps_left_ff == '0);
   assign produce    = accept && (req_tuser == brlpg_pkg::CMD_STEP) && busy_ff;

   // load setup: absolute deltas
   assign diff_x = {finish_x[C-1], finish_x} - {start_x[C-1], start_x};
   assign diff_y = {finish_y[C-1], finish_y} - {start_y[C-1], start_y};
   assign abs_x  = diff_x[C] ? -diff_x : diff_x;
   assign abs_y  = diff_y[C] ? -diff_y : diff_y;

   // step: error term decisions
   assign dx_ext = $signed({3'b000, delta_x_ff});
   assign dy_ext = $signed({3'b000, delta_y_ff});
   assign e2     = {error_ff, 1'b0};
   assign move_x = e2 > -dy_ext;
   assign move_y = e2 < dx_ext;
   assign err_wide = {error_ff[ERR_W-1], error_ff}
                     - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      steps_left_in = steps_left_ff;
      color_in      = color_ff;
      busy_in       = busy_ff;
      if (accept && req_tuser == brlpg_pkg::CMD_LOAD) begin
         cursor_x_in   = start_x;
         cursor_y_in   = start_y;
         target_x_in   = finish_x;
         target_y_in   = finish_y;
         delta_x_in    = abs_x[C-1:0];
         delta_y_in    = abs_y[C-1:0];
         step_x_neg_in = !(start_x < finish_x);
         step_y_neg_in = !(start_y < finish_y);
         error_in      = $signed({2'b00, abs_x[C-1:0]}) - $signed({2'b00, abs_y[C-1:0]});
         steps_left_in = SL_W'(STEP_LIMIT);
         color_in      = line_color;
         busy_in       = 1'b1;
      end else if (produce) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            if (move_x) begin
               cursor_x_in = step_x_neg_ff ? cursor_x_ff - C'(1) : cursor_x_ff + C'(1);
            end
            if (move_y) begin
               cursor_y_in = step_y_neg_ff ? cursor_y_ff - C'(1) : cursor_y_ff + C'(1);
            end
            error_in      = err_wide[ERR_W-1:0];
            steps_left_in = steps_left_ff - SL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         delta_x_ff    <= '0;
         delta_y_ff    <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         error_ff      <= '0;
         steps_left_ff <= '0;
         color_ff      <= '0;
         busy_ff       <= 1'b0;
      end else begin
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         delta_x_ff    <= delta_x_in;
         delta_y_ff    <= delta_y_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_ff      <= error_in;
         steps_left_ff <= steps_left_in;
         color_ff      <= color_in;
         busy_ff       <= busy_in;
      end
   end

   // pixel given: end point when finished, else current point
   assign res_x    = at_end ? target_x_ff : cursor_x_ff;
   assign res_y    = at_end ? target_y_ff : cursor_y_ff;
   assign res_last = at_end;

   // inside test, both sides widened unsigned
   assign res_inside = !res_x[C-1] && !res_y[C-1]
      && (CMP_W'($unsigned(res_x)) < CMP_W'(image_width_ff))
      && (CMP_W'($unsigned(res_y)) < CMP_W'(image_height_ff));

   assign res_data = {res_last, res_inside, color_ff, res_y, res_x};

   brlpg_skid #(
      .WIDTH(SKID_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (produce),
      .in_ready  (skid_ready),
      .in_data   (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(out_data[RSP_FIELDS_W-1:0]);
   assign rsp_tuser = out_data[RSP_FIELDS_W];
   assign rsp_tlast = out_data[RSP_FIELDS_W+1];

`ifndef SYNTHESIS
   // pixels come only from an active line
   assert property (@(posedge clock) disable iff (reset) produce |-> busy_ff)
      else $error("pixel produced while idle");

   // the end pixel closes the line
   assert property (@(posedge clock) disable iff (reset)
      (produce && res_last) |=> !busy_ff)
      else $error("line still busy after end pixel");

   // back pressure only with a result on the output
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // step budget never grows past its load value
   assert property (@(posedge clock) disable iff (reset)
      steps_left_ff <= SL_W'(STEP_LIMIT))
      else $error("step budget out of range");
`endif

endmodule
